// File: rtl/core/ncc_pkg.sv
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared widths, datapath operation codes and the controller/datapath
// command and status bundles of the nearest-centroid classifier.
// ----------------------------------------------------------------------------
package ncc_pkg;

	// fixed field widths
	localparam int COORD_W = 16;
	localparam int SUM_W   = 26;
	localparam int DIST_W  = 35;
	localparam int CFG_W   = 4;

	// shared multiplier: 27 x 27 signed, registered product
	localparam int MUL_W  = 27;
	localparam int PROD_W = 2 * MUL_W;

	// quotient bits kept by the divider; larger quotients saturate the distance
	localparam int QUO_W = 37;

	localparam logic [CFG_W-1:0]        DIMS_RESET = 4'd2;
	localparam logic signed [SUM_W-1:0] SUM_MAX    = 26'sh1FFFFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN    = 26'sh2000000;
	localparam logic [DIST_W-1:0]       DIST_MAX   = 35'h7FFFFFFFF;

	typedef logic [3:0] op_t;

	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_TRAIN    = 4'd2;
	localparam op_t OP_MUL_XX   = 4'd3;
	localparam op_t OP_MUL_X0   = 4'd4;
	localparam op_t OP_MUL_X1   = 4'd5;
	localparam op_t OP_ACC_X1   = 4'd6;
	localparam op_t OP_SS_MUL   = 4'd7;
	localparam op_t OP_SS_ACC   = 4'd8;
	localparam op_t OP_XN_INIT  = 4'd9;
	localparam op_t OP_XN_STEP  = 4'd10;
	localparam op_t OP_DIV_INIT = 4'd11;
	localparam op_t OP_DIV_STEP = 4'd12;
	localparam op_t OP_DIST     = 4'd13;
	localparam op_t OP_EMIT     = 4'd14;

	typedef struct packed {
		op_t  op;
		logic cl;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic empty;
		logic out_free;
	} stat_t;

endpackage

// File: rtl/core/ncc_ctrl.sv
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer: steps the datapath through training updates, query
// accumulation and the per-cluster distance computation.
// ----------------------------------------------------------------------------
module ncc_ctrl #(
	parameter int MAX_DIMS   = 8,
	parameter int MAX_POINTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 kind,
	output logic                                 in_ready,
	input  ncc_pkg::stat_t                       st,
	input  logic [$clog2(MAX_DIMS+1)-1:0]        dims_act,
	output ncc_pkg::cmd_t                        cmd,
	output logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] ss_dim
);
	import ncc_pkg::*;

	localparam int IW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int CT_MAX = (MAX_DIMS > QUO_W) ? MAX_DIMS : QUO_W;
	localparam int CT_W   = $clog2(CT_MAX + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TRAIN = 4'd1;
	localparam logic [3:0] S_QXX   = 4'd2;
	localparam logic [3:0] S_QX0   = 4'd3;
	localparam logic [3:0] S_QX1   = 4'd4;
	localparam logic [3:0] S_QACC  = 4'd5;
	localparam logic [3:0] S_SSM   = 4'd6;
	localparam logic [3:0] S_SSA   = 4'd7;
	localparam logic [3:0] S_XNI   = 4'd8;
	localparam logic [3:0] S_XNS   = 4'd9;
	localparam logic [3:0] S_DVI   = 4'd10;
	localparam logic [3:0] S_DVS   = 4'd11;
	localparam logic [3:0] S_DST   = 4'd12;
	localparam logic [3:0] S_EMIT  = 4'd13;

	logic [3:0]      state_q, state_d;
	logic [CT_W-1:0] cnt_q, cnt_d;
	logic            cl_q, cl_d;

	assign in_ready = (state_q == S_IDLE);
	assign ss_dim   = cnt_q[IW-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cl_d    = cl_q;
		cmd.op  = OP_NOP;
		cmd.cl  = cl_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = kind ? S_QXX : S_TRAIN;
				end
			end
			S_TRAIN: begin
				cmd.op  = OP_TRAIN;
				state_d = S_IDLE;
			end
			S_QXX: begin
				cmd.op  = OP_MUL_XX;
				state_d = S_QX0;
			end
			S_QX0: begin
				cmd.op  = OP_MUL_X0;
				state_d = S_QX1;
			end
			S_QX1: begin
				cmd.op  = OP_MUL_X1;
				state_d = S_QACC;
			end
			S_QACC: begin
				cmd.op = OP_ACC_X1;
				cl_d   = 1'b0;
				cnt_d  = '0;
				if (!st.last) begin
					state_d = S_IDLE;
				end else if (st.empty) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_SSM;
				end
			end
			S_SSM: begin
				cmd.op  = OP_SS_MUL;
				cnt_d   = cnt_q + 1'b1;
				state_d = S_SSA;
			end
			S_SSA: begin
				cmd.op  = OP_SS_ACC;
				state_d = (cnt_q == CT_W'(dims_act)) ? S_XNI : S_SSM;
			end
			S_XNI: begin
				cmd.op  = OP_XN_INIT;
				cnt_d   = '0;
				state_d = S_XNS;
			end
			S_XNS: begin
				cmd.op = OP_XN_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CT_W'(CNT_W - 1)) begin
					state_d = S_DVI;
				end
			end
			S_DVI: begin
				cmd.op  = OP_DIV_INIT;
				cnt_d   = '0;
				state_d = S_DVS;
			end
			S_DVS: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CT_W'(QUO_W - 1)) begin
					state_d = S_DST;
				end
			end
			S_DST: begin
				cmd.op = OP_DIST;
				cnt_d  = '0;
				if (!cl_q) begin
					cl_d    = 1'b1;
					state_d = S_SSM;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			cl_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cl_q    <= cl_d;
		end
	end

endmodule

// File: rtl/core/ncc_dp.sv
// ----------------------------------------------------------------------------
// ncc_dp
// Datapath: cluster sums and counts, shared multiplier, dot-product
// accumulators, shift-add multiplier, restoring divider, result register.
// ----------------------------------------------------------------------------
module ncc_dp #(
	parameter int MAX_DIMS   = 8,
	parameter int MAX_POINTS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ncc_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 label,
	input  logic signed [ncc_pkg::COORD_W-1:0]   coord,
	input  ncc_pkg::cmd_t                        cmd,
	input  logic [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] ss_dim,
	output ncc_pkg::stat_t                       st,
	output logic [$clog2(MAX_DIMS+1)-1:0]        dims_act,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 class_out,
	output logic [ncc_pkg::DIST_W-1:0]           dist_zero,
	output logic [ncc_pkg::DIST_W-1:0]           dist_one,
	output logic                                 empty_flag
);
	import ncc_pkg::*;

	localparam int IW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DW     = $clog2(MAX_DIMS);
	localparam int AD_W   = $clog2(MAX_DIMS + 1);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SD_W   = 2 * COORD_W - 1 + DW;
	localparam int XD_W   = COORD_W + SUM_W + DW;
	localparam int SS_W   = 2 * SUM_W - 1 + DW;
	localparam int REM_A  = SS_W + 1;
	localparam int REM_B  = XD_W + CNT_W + 1;
	localparam int REM_W  = ((REM_A > REM_B) ? REM_A : REM_B) + 1;
	localparam int DEN_W  = 2 * CNT_W;
	localparam int VW     = ((SD_W > QUO_W) ? SD_W : QUO_W) + 2;

	// architectural state
	logic [CFG_W-1:0]        dims_q;
	logic signed [SUM_W-1:0] sum_q [2][MAX_DIMS];
	logic [CNT_W-1:0]        cnt_q [2];
	logic [IW-1:0]           cidx_q;
	logic [SD_W-1:0]         self_dot_q;
	logic signed [XD_W-1:0]  xd_q [2];
	logic [SS_W-1:0]         ss_q;

	// working registers
	logic                     lbl_q;
	logic signed [COORD_W-1:0] x_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [REM_W-1:0]  xn_acc_q, xn_mc_q;
	logic [CNT_W-1:0]         xn_mp_q;
	logic [DEN_W-1:0]         den_q, part_q;
	logic [QUO_W-1:0]         qsr_q;
	logic                     neg_q, ovf_q;
	logic [DIST_W-1:0]        dist_q [2];

	logic                     out_valid_q, class_q, empty_q;
	logic [DIST_W-1:0]        dz_q, d1_q;

	// active dimension count, clamped
	always_comb begin
		if (dims_q == '0) begin
			dims_act = AD_W'(1);
		end else if (int'(dims_q) > MAX_DIMS) begin
			dims_act = AD_W'(MAX_DIMS);
		end else begin
			dims_act = AD_W'(dims_q);
		end
	end

	logic [IW:0] cidx_p1;
	logic        last;
	assign cidx_p1 = {1'b0, cidx_q} + 1'b1;
	assign last    = (cidx_p1 >= (IW+1)'(dims_act));

	assign st.last     = last;
	assign st.empty    = (cnt_q[0] == '0) || (cnt_q[1] == '0);
	assign st.out_free = !out_valid_q || out_ready;

	// single read port on the sum store
	logic                    rd_cl;
	logic [IW-1:0]           rd_dim;
	logic signed [SUM_W-1:0] rd_sum;

	always_comb begin
		rd_cl  = lbl_q;
		rd_dim = cidx_q;
		case (cmd.op)
			OP_MUL_X0: rd_cl = 1'b0;
			OP_MUL_X1: rd_cl = 1'b1;
			OP_SS_MUL: begin
				rd_cl  = cmd.cl;
				rd_dim = ss_dim;
			end
			default: ;
		endcase
	end
	assign rd_sum = sum_q[rd_cl][rd_dim];

	// training update with saturation
	logic signed [SUM_W:0]   tr_add;
	logic signed [SUM_W-1:0] tr_sat;
	logic                    can_train;

	assign tr_add    = (SUM_W+1)'(rd_sum) + (SUM_W+1)'(x_q);
	assign tr_sat    = (tr_add[SUM_W] != tr_add[SUM_W-1]) ?
	                   (tr_add[SUM_W] ? SUM_MIN : SUM_MAX) : tr_add[SUM_W-1:0];
	assign can_train = cnt_q[lbl_q] < CNT_W'(MAX_POINTS);

	// shared multiplier operands
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic                    mul_en;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op) inside
			OP_MUL_XX: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(x_q);
			end
			OP_MUL_X0, OP_MUL_X1: begin
				mul_a = MUL_W'(x_q);
				mul_b = MUL_W'(rd_sum);
			end
			OP_SS_MUL: begin
				mul_a = MUL_W'(rd_sum);
				mul_b = MUL_W'(rd_sum);
			end
			OP_XN_INIT: begin
				mul_a = MUL_W'(cnt_q[cmd.cl]);
				mul_b = MUL_W'(cnt_q[cmd.cl]);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// divider setup: rem = S.S - 2 n x.S, split into sign and magnitude
	logic signed [REM_W-1:0] rem;
	logic [REM_W-1:0]        rem_u, mag, hi;
	logic [DEN_W-1:0]        den_w;
	logic                    rem_neg, div_ovf;

	assign rem     = $signed({{(REM_W-SS_W){1'b0}}, ss_q}) - (xn_acc_q <<< 1);
	assign rem_u   = rem;
	assign rem_neg = rem[REM_W-1];
	assign mag     = rem_neg ? (~rem_u + 1'b1) : rem_u;
	assign hi      = mag >> QUO_W;
	assign den_w   = prod_q[DEN_W-1:0];
	assign div_ovf = hi >= {{(REM_W-DEN_W){1'b0}}, den_w};

	// one restoring step
	logic [DEN_W:0] trial, trial_sub;
	logic           trial_ge;

	assign trial     = {part_q, qsr_q[QUO_W-1]};
	assign trial_ge  = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	// distance = x.x + floor(rem / n^2), clamped
	logic [QUO_W:0]    qm;
	logic [VW-1:0]     sd_ext, q_ext, v_u;
	logic [DIST_W-1:0] dist_val;

	assign qm     = {1'b0, qsr_q} + {{QUO_W{1'b0}}, (neg_q && (part_q != '0))};
	assign sd_ext = VW'(self_dot_q);
	assign q_ext  = VW'(qm);
	assign v_u    = neg_q ? (sd_ext - q_ext) : (sd_ext + q_ext);

	always_comb begin
		if (ovf_q) begin
			dist_val = neg_q ? '0 : DIST_MAX;
		end else if (v_u[VW-1]) begin
			dist_val = '0;
		end else if (v_u[VW-2:DIST_W] != '0) begin
			dist_val = DIST_MAX;
		end else begin
			dist_val = v_u[DIST_W-1:0];
		end
	end

	// state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q      <= DIMS_RESET;
			for (int c = 0; c < 2; c++) begin
				for (int d = 0; d < MAX_DIMS; d++) begin
					sum_q[c][d] <= '0;
				end
				cnt_q[c] <= '0;
				xd_q[c]  <= '0;
			end
			cidx_q      <= '0;
			self_dot_q  <= '0;
			ss_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dims_q <= cfg_data;
			end
			// a new result loaded in the same cycle keeps valid high
			if (out_valid_q && out_ready && (cmd.op != OP_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op) inside
				OP_TRAIN: begin
					if (can_train) begin
						sum_q[lbl_q][cidx_q] <= tr_sat;
						if (last) begin
							cnt_q[lbl_q] <= cnt_q[lbl_q] + 1'b1;
						end
					end
					if (last) begin
						cidx_q     <= '0;
						self_dot_q <= '0;
						xd_q[0]    <= '0;
						xd_q[1]    <= '0;
					end else begin
						cidx_q <= cidx_p1[IW-1:0];
					end
				end
				OP_MUL_X0: self_dot_q <= self_dot_q + prod_q[SD_W-1:0];
				OP_MUL_X1: xd_q[0] <= xd_q[0] + $signed(prod_q[XD_W-1:0]);
				OP_ACC_X1: begin
					xd_q[1] <= xd_q[1] + $signed(prod_q[XD_W-1:0]);
					if (!last) begin
						cidx_q <= cidx_p1[IW-1:0];
					end
				end
				OP_SS_ACC: ss_q <= ss_q + prod_q[SS_W-1:0];
				OP_DIST:   ss_q <= '0;
				OP_EMIT: begin
					out_valid_q <= 1'b1;
					cidx_q      <= '0;
					self_dot_q  <= '0;
					xd_q[0]     <= '0;
					xd_q[1]     <= '0;
				end
				OP_NOP, OP_LOAD, OP_MUL_XX, OP_SS_MUL, OP_XN_INIT, OP_XN_STEP,
				OP_DIV_INIT, OP_DIV_STEP: ;
				default: ;
			endcase
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.op)
			OP_LOAD: begin
				lbl_q <= label;
				x_q   <= coord;
			end
			OP_XN_INIT: begin
				xn_acc_q <= '0;
				xn_mc_q  <= REM_W'(xd_q[cmd.cl]);
				xn_mp_q  <= cnt_q[cmd.cl];
			end
			OP_XN_STEP: begin
				if (xn_mp_q[0]) begin
					xn_acc_q <= xn_acc_q + xn_mc_q;
				end
				xn_mc_q <= xn_mc_q <<< 1;
				xn_mp_q <= xn_mp_q >> 1;
			end
			OP_DIV_INIT: begin
				den_q  <= den_w;
				part_q <= hi[DEN_W-1:0];
				qsr_q  <= mag[QUO_W-1:0];
				neg_q  <= rem_neg;
				ovf_q  <= div_ovf;
			end
			OP_DIV_STEP: begin
				part_q <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
				qsr_q  <= {qsr_q[QUO_W-2:0], trial_ge};
			end
			OP_DIST: dist_q[cmd.cl] <= dist_val;
			OP_EMIT: begin
				if (st.empty) begin
					class_q <= 1'b0;
					dz_q    <= '0;
					d1_q    <= '0;
					empty_q <= 1'b1;
				end else begin
					class_q <= !(dist_q[0] < dist_q[1]);
					dz_q    <= dist_q[0];
					d1_q    <= dist_q[1];
					empty_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign class_out  = class_q;
	assign dist_zero  = dz_q;
	assign dist_one   = d1_q;
	assign empty_flag = empty_q;

endmodule

// File: rtl/core/nearest_centroid_two_class_core.sv
// ----------------------------------------------------------------------------
// nearest_centroid_two_class_core
// training request: load, then one training update; query request that does not end a
// point: load, the x.x, x.S0 and x.S1 products, then accumulate; a query request ending
//   a point adds, once per cluster, the sum-of-squares walk, the shift-add n * x.S multiply
//   over CNT_W = clog2(MAX_POINTS + 1) bits and the 37-step divider
// empty cluster at the last query coordinate: no distance computed, flagged result
// arst_n clears sums, counts and accumulators at once; dims_in_use resets to 2
// ----------------------------------------------------------------------------
module nearest_centroid_two_class_core #(
	parameter int MAX_DIMS   = 8,
	parameter int MAX_POINTS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ncc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic                               label,
	input  logic signed [ncc_pkg::COORD_W-1:0] coord,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               class_out,
	output logic [ncc_pkg::DIST_W-1:0]         dist_zero,
	output logic [ncc_pkg::DIST_W-1:0]         dist_one,
	output logic                               empty_flag
);
	import ncc_pkg::*;

	// index width of one dimension, and of the clamped dimension count
	localparam int IW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int AD_W = $clog2(MAX_DIMS + 1);

	// controller to datapath: one operation a cycle plus the cluster it targets
	cmd_t            cmd;
	// datapath to controller: point complete, a cluster empty, result slot free
	stat_t           st;
	logic [AD_W-1:0] dims_act;
	// dimension being walked while summing S.S
	logic [IW-1:0]   ss_dim;

	// sequencer: takes a request only when idle; a finished result waits in
	// the datapath's output register, so the next request can enter meanwhile
	ncc_ctrl #(
		.MAX_DIMS   (MAX_DIMS),
		.MAX_POINTS (MAX_POINTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.st       (st),
		.dims_act (dims_act),
		.cmd      (cmd),
		.ss_dim   (ss_dim)
	);

	// datapath: sum store, counts, shared 27x27 multiplier, divider and the
	// output register that holds a result until out_ready takes it
	ncc_dp #(
		.MAX_DIMS   (MAX_DIMS),
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.label      (label),
		.coord      (coord),
		.cmd        (cmd),
		.ss_dim     (ss_dim),
		.st         (st),
		.dims_act   (dims_act),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.class_out  (class_out),
		.dist_zero  (dist_zero),
		.dist_one   (dist_one),
		.empty_flag (empty_flag)
	);

endmodule
